// ----- design/plz_pkg.sv -----
// ----------------------------------------------------------------------------
// Pauli localizer package
// Shared command type, mode and gate codes, and the lowest-set-axis search.
// ----------------------------------------------------------------------------
package plz_pkg;

    localparam int unsigned AxisW = 5;
    localparam int unsigned MaskW = 32;
    localparam int unsigned CountW = 6;

    localparam logic [1:0] GATE_CNOT = 2'd0;
    localparam logic [1:0] GATE_CZ   = 2'd1;
    localparam logic [1:0] GATE_S    = 2'd2;
    localparam logic [1:0] GATE_DONE = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDENT,
        MODE_X,
        MODE_Z
    } t_mode;

    // One classified string, as the sequencer needs it.
    typedef struct packed {
        t_mode              mode;
        logic [MaskW-1:0]   xrest;
        logic [MaskW-1:0]   zrest;
        logic               sign;
        logic               zp;
        logic [AxisW-1:0]   piv;
        logic [CountW-1:0]  k;
    } t_cmd;

    function automatic logic [AxisW-1:0] lowest_axis(input logic [MaskW-1:0] m);
        logic [AxisW-1:0] r;
        r = '0;
        for (int i = MaskW - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = AxisW'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- design/plz_front.sv -----
// ----------------------------------------------------------------------------
// Pauli localizer front end
// Accepts a string, masks it to the qubit range, picks the pivot and
// registers the classified command for the queue.
// ----------------------------------------------------------------------------
module plz_front
    import plz_pkg::*;
#(
    parameter int unsigned QUBITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MaskW-1:0]  i_x_mask,
    input  logic [MaskW-1:0]  i_z_mask,
    input  logic              i_sign_in,
    input  logic [CountW-1:0] i_active_count,
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_full
);

    localparam logic [MaskW:0] LaneFull = (33'd1 << QUBITS) - 33'd1;
    localparam logic [CountW-1:0] QubitCount = CountW'(QUBITS);

    logic              r_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              accept;
    logic [MaskW-1:0]  xs;
    logic [MaskW-1:0]  zs;
    logic [CountW-1:0] k;
    logic [MaskW:0]    kfull;
    logic [MaskW-1:0]  kmask;
    logic [MaskW-1:0]  dormant_x;
    logic [MaskW-1:0]  active_z;
    logic [AxisW-1:0]  piv;
    logic [MaskW-1:0]  piv_bit;

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    always_comb begin
        xs = i_x_mask & LaneFull[MaskW-1:0];
        zs = i_z_mask & LaneFull[MaskW-1:0];
        k  = (i_active_count > QubitCount) ? QubitCount : i_active_count;
        kfull = ((MaskW+1)'(1) << k) - (MaskW+1)'(1);
        kmask = kfull[MaskW-1:0];
        dormant_x = xs & ~kmask;
        active_z  = zs & kmask;
        // X strings prefer a dormant pivot, Z strings an active one.
        if (xs != '0) begin
            piv = lowest_axis((dormant_x != '0) ? dormant_x : xs);
        end else begin
            piv = lowest_axis((active_z != '0) ? active_z : zs);
        end
        piv_bit = MaskW'(1) << piv;
        n_cmd.sign  = i_sign_in;
        n_cmd.k     = k;
        n_cmd.piv   = piv;
        n_cmd.zp    = zs[piv];
        n_cmd.xrest = xs & ~piv_bit;
        n_cmd.zrest = zs & ~piv_bit;
        if (xs == '0 && zs == '0) begin
            n_cmd.mode = MODE_IDENT;
        end else if (xs != '0) begin
            n_cmd.mode = MODE_X;
        end else begin
            n_cmd.mode = MODE_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || o_stall;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- design/plz_queue.sv -----
// ----------------------------------------------------------------------------
// Pauli localizer command queue
// Two-entry queue that lets the front end and the sequencer stall apart.
// ----------------------------------------------------------------------------
module plz_queue
    import plz_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    t_cmd       r_mem [2];

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ----- design/plz_back.sv -----
// ----------------------------------------------------------------------------
// Pauli localizer sequencer
// Walks the remaining masks of one command, one gate word per cycle while the
// output is not stalled, and closes with the done word in a registered output stage.
// ----------------------------------------------------------------------------
module plz_back
    import plz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_gate_kind,
    output logic             o_on_array,
    output logic [AxisW-1:0] o_first_axis,
    output logic [AxisW-1:0] o_second_axis,
    output logic [AxisW-1:0] o_pivot,
    output logic             o_basis_x,
    output logic             o_sign_out,
    output logic             o_identity_error,
    output logic             o_last
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              r_valid;
    logic [1:0]        r_kind;
    logic              r_arr;
    logic [AxisW-1:0]  r_first;
    logic [AxisW-1:0]  r_second;
    logic [AxisW-1:0]  r_pivot;
    logic              r_basis;
    logic              r_sign;
    logic              r_err;
    logic              r_last;
    logic [1:0]        n_kind;
    logic              n_arr;
    logic [AxisW-1:0]  n_first;
    logic [AxisW-1:0]  n_second;
    logic [AxisW-1:0]  n_pivot;
    logic              n_basis;
    logic              n_sign;
    logic              n_err;
    logic              n_last;
    logic              adv;
    logic              x_left;
    logic [AxisW-1:0]  q;
    logic [MaskW-1:0]  q_bit;
    logic              piv_act;
    logic              q_act;

    assign adv    = !r_valid || !i_stall;
    assign o_pop  = (r_state == ST_IDLE) && !i_empty;
    assign x_left = (r_cmd.mode == MODE_X) && (r_cmd.xrest != '0);

    always_comb begin
        q       = lowest_axis(x_left ? r_cmd.xrest : r_cmd.zrest);
        q_bit   = MaskW'(1) << q;
        piv_act = {1'b0, r_cmd.piv} < r_cmd.k;
        q_act   = {1'b0, q} < r_cmd.k;
        n_cmd    = r_cmd;
        n_kind   = GATE_CNOT;
        n_arr    = 1'b0;
        n_first  = '0;
        n_second = '0;
        n_pivot  = '0;
        n_basis  = 1'b0;
        n_sign   = 1'b0;
        n_err    = 1'b0;
        n_last   = 1'b0;
        priority if (x_left) begin
            // Clearing an X bit drags that axis's Z onto the pivot.
            n_arr    = piv_act;
            n_first  = r_cmd.piv;
            n_second = q;
            n_cmd.xrest = r_cmd.xrest & ~q_bit;
            if (r_cmd.zrest[q]) begin
                n_cmd.zp   = ~r_cmd.zp;
                n_cmd.sign = r_cmd.sign ^ r_cmd.zp;
            end
        end else if (r_cmd.mode == MODE_X && r_cmd.zrest != '0) begin
            n_kind   = GATE_CZ;
            n_arr    = piv_act && q_act;
            n_first  = r_cmd.piv;
            n_second = q;
            n_cmd.zrest = r_cmd.zrest & ~q_bit;
        end else if (r_cmd.mode == MODE_X && r_cmd.zp) begin
            n_kind     = GATE_S;
            n_arr      = piv_act;
            n_first    = r_cmd.piv;
            n_cmd.zp   = 1'b0;
            n_cmd.sign = ~r_cmd.sign;
        end else if (r_cmd.mode == MODE_Z && r_cmd.zrest != '0) begin
            n_arr    = q_act;
            n_first  = q;
            n_second = r_cmd.piv;
            n_cmd.zrest = r_cmd.zrest & ~q_bit;
        end else begin
            n_kind  = GATE_DONE;
            n_pivot = (r_cmd.mode == MODE_IDENT) ? '0 : r_cmd.piv;
            n_basis = (r_cmd.mode == MODE_X);
            n_sign  = r_cmd.sign;
            n_err   = (r_cmd.mode == MODE_IDENT);
            n_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (adv) begin
                        r_valid <= 1'b0;
                    end
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (adv) begin
                        r_valid  <= 1'b1;
                        r_kind   <= n_kind;
                        r_arr    <= n_arr;
                        r_first  <= n_first;
                        r_second <= n_second;
                        r_pivot  <= n_pivot;
                        r_basis  <= n_basis;
                        r_sign   <= n_sign;
                        r_err    <= n_err;
                        r_last   <= n_last;
                        r_cmd    <= n_cmd;
                        if (n_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_gate_kind      = r_kind;
    assign o_on_array       = r_arr;
    assign o_first_axis     = r_first;
    assign o_second_axis    = r_second;
    assign o_pivot          = r_pivot;
    assign o_basis_x        = r_basis;
    assign o_sign_out       = r_sign;
    assign o_identity_error = r_err;
    assign o_last           = r_last;

endmodule

// ----- design/pauli_localizer_unit.sv -----
// ----------------------------------------------------------------------------
// Pauli localizer unit
// Reduces a Pauli string to one single-qubit X or Z and emits the gates.
// ----------------------------------------------------------------------------
// Each accepted string yields its CNOT, CZ and S words followed by one done
// word marked last, at one word per cycle while the output is not stalled.
// The sequencer loads each command in its idle state and then emits its words
// from its busy state; a string with g gates has g at most 2*QUBITS - 1.
// It finds one remaining axis per cycle while the output is not stalled.
// The front end classifies the next string and a two-entry queue holds
// pending commands, so input is taken while earlier strings are emitted.
// ----------------------------------------------------------------------------
module pauli_localizer_unit
    import plz_pkg::*;
#(
    parameter int unsigned QUBITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MaskW-1:0]  i_x_mask,
    input  logic [MaskW-1:0]  i_z_mask,
    input  logic              i_sign_in,
    input  logic [CountW-1:0] i_active_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_gate_kind,
    output logic              o_on_array,
    output logic [AxisW-1:0]  o_first_axis,
    output logic [AxisW-1:0]  o_second_axis,
    output logic [AxisW-1:0]  o_pivot,
    output logic              o_basis_x,
    output logic              o_sign_out,
    output logic              o_identity_error,
    output logic              o_last
);

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    plz_front #(
        .QUBITS(QUBITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_mask       (i_x_mask),
        .i_z_mask       (i_z_mask),
        .i_sign_in      (i_sign_in),
        .i_active_count (i_active_count),
        .o_push         (push),
        .o_cmd          (front_cmd),
        .i_full         (full)
    );

    plz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    plz_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_gate_kind      (o_gate_kind),
        .o_on_array       (o_on_array),
        .o_first_axis     (o_first_axis),
        .o_second_axis    (o_second_axis),
        .o_pivot          (o_pivot),
        .o_basis_x        (o_basis_x),
        .o_sign_out       (o_sign_out),
        .o_identity_error (o_identity_error),
        .o_last           (o_last)
    );

endmodule
